### src/strs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strs_pkg: shared types and constants of the range-sum tree
// ops codes, widths, queue entry type and sequencer states
// ----------------------------------------------------------------------------
package strs_pkg;

  localparam int unsigned MaxElements = 1024;
  localparam int unsigned IdxW        = 10;
  localparam int unsigned NodeW       = IdxW + 1;
  localparam int unsigned NodeDepth   = 2 * MaxElements;
  localparam int unsigned CountW      = 11;
  localparam int unsigned DataW       = 32;
  localparam int unsigned QDepth      = 2;

  typedef enum logic [1:0] {
    OpLoad     = 2'd0,
    OpWithdraw = 2'd1,
    OpDeposit  = 2'd2,
    OpSum      = 2'd3
  } op_e;

  // classified command handed from front to back
  typedef struct packed {
    op_e              op;
    logic             err;
    logic             empty;
    logic [IdxW-1:0]  lo;
    logic [IdxW-1:0]  hi;
    logic [DataW-1:0] amount;
  } cmd_t;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StLeafRd,
    StLeafWt,
    StUpRd,
    StUpWt0,
    StUpWt1,
    StSumStep,
    StSumRdL,
    StSumRdR,
    StSumWtL,
    StSumWtR,
    StDone
  } state_e;

endpackage

### src/strs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strs_ram: generic single-port ram
// one write or one read per cycle, registered read data
// ----------------------------------------------------------------------------
module strs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/strs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strs_front: input classifier and command queue
// checks index ranges against the element count and queues commands
// ----------------------------------------------------------------------------
module strs_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [strs_pkg::CountW-1:0]  count_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   in_op_i,
  input  logic [strs_pkg::IdxW-1:0]    in_index_i,
  input  logic [strs_pkg::IdxW-1:0]    in_end_i,
  input  logic [strs_pkg::DataW-1:0]   in_amount_i,
  output logic                         cmd_valid_o,
  input  logic                         cmd_ready_i,
  output strs_pkg::cmd_t               cmd_o
);

  strs_pkg::cmd_t cmd_q [strs_pkg::QDepth];
  logic           wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]     fill_q, fill_d;
  logic [strs_pkg::NodeW-1:0] n_eff;
  strs_pkg::cmd_t cmd_new;
  logic           push, pop;

  always_comb begin
    n_eff = (count_i > strs_pkg::CountW'(strs_pkg::MaxElements)) ?
            strs_pkg::NodeW'(strs_pkg::MaxElements) : strs_pkg::NodeW'(count_i);
    cmd_new.op     = strs_pkg::op_e'(in_op_i);
    cmd_new.lo     = in_index_i;
    cmd_new.hi     = in_end_i;
    cmd_new.amount = in_amount_i;
    cmd_new.err    = ({1'b0, in_index_i} >= n_eff) ||
                     ((cmd_new.op == strs_pkg::OpSum) && ({1'b0, in_end_i} >= n_eff));
    cmd_new.empty  = (in_index_i > in_end_i);
  end

  assign in_ready_o  = (fill_q != 2'(strs_pkg::QDepth));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = cmd_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

### src/strs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strs_back: tree walker
// clears the node ram after reset, then runs leaf updates and range sums
// with at most one node access per cycle, and holds the result in an output register
// ----------------------------------------------------------------------------
module strs_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  output logic                       cmd_ready_o,
  input  strs_pkg::cmd_t             cmd_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output logic [strs_pkg::DataW-1:0] res_value_o,
  output logic                       res_status_o
);

  localparam int unsigned NW = strs_pkg::NodeW;
  localparam int unsigned DW = strs_pkg::DataW;

  strs_pkg::state_e  state_q, state_d;
  strs_pkg::cmd_t    cmd_q, cmd_d;
  logic [NW-1:0]     p_q, p_d;
  logic [NW:0]       l_q, l_d, r_q, r_d, r_dec;
  logic [NW:0]       clr_q, clr_d;
  logic [DW-1:0]     acc_q, acc_d, val_q, val_d;
  logic              rv_q, rv_d;
  logic [DW-1:0]     rs_value_q, rs_value_d;
  logic              rs_status_q, rs_status_d;

  logic              ram_we;
  logic [NW-1:0]     ram_addr;
  logic [DW-1:0]     ram_wdata, ram_rdata;

  strs_ram #(.Width(DW), .Depth(strs_pkg::NodeDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign res_valid_o  = rv_q;
  assign res_value_o  = rs_value_q;
  assign res_status_o = rs_status_q;
  assign r_dec        = r_q - 1'b1;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    p_d         = p_q;
    l_d         = l_q;
    r_d         = r_q;
    clr_d       = clr_q;
    acc_d       = acc_q;
    val_d       = val_q;
    rv_d        = rv_q && !res_ready_i;
    rs_value_d  = rs_value_q;
    rs_status_d = rs_status_q;
    ram_we      = 1'b0;
    ram_addr    = p_q;
    ram_wdata   = val_q;
    cmd_ready_o = 1'b0;
    unique case (state_q)
      strs_pkg::StClear: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q[NW-1:0];
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == (NW+1)'(strs_pkg::NodeDepth - 1)) begin
          state_d = strs_pkg::StIdle;
        end
      end
      strs_pkg::StIdle: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          p_d   = NW'(strs_pkg::MaxElements) + NW'(cmd_i.lo);
          l_d   = (NW+1)'(strs_pkg::MaxElements) + (NW+1)'(cmd_i.lo);
          r_d   = (NW+1)'(strs_pkg::MaxElements) + (NW+1)'(cmd_i.hi) + 1'b1;
          acc_d = '0;
          if (cmd_i.err || (cmd_i.op == strs_pkg::OpSum && cmd_i.empty)) begin
            state_d = strs_pkg::StDone;
          end else if (cmd_i.op == strs_pkg::OpSum) begin
            state_d = strs_pkg::StSumStep;
          end else begin
            state_d = strs_pkg::StLeafRd;
          end
        end
      end
      strs_pkg::StLeafRd: begin
        state_d = strs_pkg::StLeafWt;
      end
      strs_pkg::StLeafWt: begin
        case (cmd_q.op)
          strs_pkg::OpLoad:     val_d = cmd_q.amount;
          strs_pkg::OpWithdraw: begin
            val_d = '0;
            acc_d = ram_rdata;
          end
          default:              val_d = ram_rdata + cmd_q.amount;
        endcase
        ram_we    = 1'b1;
        ram_wdata = val_d;
        state_d   = strs_pkg::StUpRd;
      end
      strs_pkg::StUpRd: begin
        if (p_q == NW'(1)) begin
          state_d = strs_pkg::StDone;
        end else begin
          ram_addr = p_q ^ NW'(1);
          state_d  = strs_pkg::StUpWt0;
        end
      end
      strs_pkg::StUpWt0: begin
        ram_addr = p_q ^ NW'(1);
        state_d  = strs_pkg::StUpWt1;
      end
      strs_pkg::StUpWt1: begin
        p_d       = p_q >> 1;
        val_d     = val_q + ram_rdata;
        ram_we    = 1'b1;
        ram_addr  = p_d;
        ram_wdata = val_d;
        state_d   = strs_pkg::StUpRd;
      end
      strs_pkg::StSumStep: begin
        if (l_q >= r_q) begin
          state_d = strs_pkg::StDone;
        end else if (l_q[0]) begin
          ram_addr = l_q[NW-1:0];
          l_d      = l_q + 1'b1;
          state_d  = strs_pkg::StSumRdL;
        end else if (r_q[0]) begin
          ram_addr = r_dec[NW-1:0];
          r_d      = r_dec;
          state_d  = strs_pkg::StSumRdR;
        end else begin
          l_d = l_q >> 1;
          r_d = r_q >> 1;
        end
      end
      strs_pkg::StSumRdL: begin
        ram_addr = l_q[NW-1:0] - 1'b1;
        state_d  = strs_pkg::StSumWtL;
      end
      strs_pkg::StSumWtL: begin
        acc_d = acc_q + ram_rdata;
        if (r_q[0]) begin
          ram_addr = r_dec[NW-1:0];
          r_d      = r_dec;
          state_d  = strs_pkg::StSumRdR;
        end else begin
          l_d     = l_q >> 1;
          r_d     = r_q >> 1;
          state_d = strs_pkg::StSumStep;
        end
      end
      strs_pkg::StSumRdR: begin
        ram_addr = r_q[NW-1:0];
        state_d  = strs_pkg::StSumWtR;
      end
      strs_pkg::StSumWtR: begin
        acc_d   = acc_q + ram_rdata;
        l_d     = l_q >> 1;
        r_d     = r_q >> 1;
        state_d = strs_pkg::StSumStep;
      end
      strs_pkg::StDone: begin
        if (!rv_q || res_ready_i) begin
          rv_d        = 1'b1;
          rs_status_d = cmd_q.err;
          rs_value_d  = (cmd_q.err || cmd_q.op == strs_pkg::OpLoad ||
                         cmd_q.op == strs_pkg::OpDeposit) ? '0 : acc_q;
          state_d     = strs_pkg::StIdle;
        end
      end
      default: state_d = strs_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= strs_pkg::StClear;
      clr_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    p_q         <= p_d;
    l_q         <= l_d;
    r_q         <= r_d;
    acc_q       <= acc_d;
    val_q       <= val_d;
    rs_value_q  <= rs_value_d;
    rs_status_q <= rs_status_d;
  end

endmodule

### src/segment_tree_range_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_tree_range_sum: sum tree over 1024 words with range queries
// After reset the walker clears all 2048 node ram words before it takes the
// first beat. A load, withdraw or deposit reads and writes the leaf and then,
// for each tree level, reads the sibling and writes the parent sum on the
// single-port node ram; a range sum climbs the tree level by level and reads
// each boundary node in the range. Out of range beats and reversed range sums
// skip the tree and go straight to the result. A two-entry command queue lets
// up to two beats be taken while the walker is busy.
// ----------------------------------------------------------------------------
module segment_tree_range_sum (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // operation
  input  logic [55:0] s_axis_tdata,   // index, range_end, amount, 4 bits zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // value, status, 7 bits zero
);

  logic [strs_pkg::CountW-1:0] count_q;
  logic                        cmd_valid, cmd_ready;
  strs_pkg::cmd_t              cmd;
  logic [strs_pkg::DataW-1:0]  res_value;
  logic                        res_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= strs_pkg::CountW'(1024);
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  strs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .count_i     (count_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_index_i  (s_axis_tdata[9:0]),
    .in_end_i    (s_axis_tdata[19:10]),
    .in_amount_i (s_axis_tdata[51:20]),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  strs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_value_o  (res_value),
    .res_status_o (res_status)
  );

  assign m_axis_tdata = {7'd0, res_status, res_value};

endmodule
